// File: design/isqrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root package
// Shared widths, constants, microcode encodings and the control store.
// ----------------------------------------------------------------------------
package isqrt_pkg;

  localparam int VALUE_W       = 64;
  localparam int ROOT_W        = 32;
  localparam int MAG_W         = VALUE_W - 1;
  localparam int EST_W         = 50;
  localparam int NEWTON_STEPS_DEFAULT = 15;
  localparam logic [EST_W-1:0] START_ESTIMATE = EST_W'(16'h3fff);

  localparam int DIV_CNT_W     = $clog2(MAG_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(MAG_W - 1);

  localparam int PC_W          = 3;
  localparam int OP_W          = 3;
  localparam int COND_W        = 3;

  localparam logic [OP_W-1:0] OP_LOAD     = 3'd0;
  localparam logic [OP_W-1:0] OP_NONE     = 3'd1;
  localparam logic [OP_W-1:0] OP_DIV_INIT = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV_STEP = 3'd3;
  localparam logic [OP_W-1:0] OP_UPDATE   = 3'd4;
  localparam logic [OP_W-1:0] OP_EMIT     = 3'd5;

  localparam logic [COND_W-1:0] COND_NEVER     = 3'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS    = 3'd1;
  localparam logic [COND_W-1:0] COND_NOT_START = 3'd2;
  localparam logic [COND_W-1:0] COND_STOP      = 3'd3;
  localparam logic [COND_W-1:0] COND_DIV_BUSY  = 3'd4;

  localparam logic [PC_W-1:0] PC_IDLE   = 3'd0;
  localparam logic [PC_W-1:0] PC_CHECK  = 3'd1;
  localparam logic [PC_W-1:0] PC_DINIT  = 3'd2;
  localparam logic [PC_W-1:0] PC_DSTEP  = 3'd3;
  localparam logic [PC_W-1:0] PC_UPDATE = 3'd4;
  localparam logic [PC_W-1:0] PC_EMIT   = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ctrl_t;

  function automatic ctrl_t control_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_IDLE:   w = '{op: OP_LOAD,     cond: COND_NOT_START, target: PC_IDLE};
      PC_CHECK:  w = '{op: OP_NONE,     cond: COND_STOP,      target: PC_EMIT};
      PC_DINIT:  w = '{op: OP_DIV_INIT, cond: COND_NEVER,     target: PC_IDLE};
      PC_DSTEP:  w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY,  target: PC_DSTEP};
      PC_UPDATE: w = '{op: OP_UPDATE,   cond: COND_ALWAYS,    target: PC_CHECK};
      PC_EMIT:   w = '{op: OP_EMIT,     cond: COND_ALWAYS,    target: PC_IDLE};
      default:   w = '{op: OP_NONE,     cond: COND_ALWAYS,    target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: design/integer_sqrt_newton_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root, Newton's method
// Sequence: load in idle, check, divider init, bit-serial restoring divider
// steps, update, back to check; at most NEWTON_STEPS updates are made.
// Busy stays high through the result strobe, so a new radicand is taken only
// in idle. A negative radicand goes straight from the check to the result strobe.
// Reset returns the sequencer to idle; the receiver cannot stall a result.
// ----------------------------------------------------------------------------
module integer_sqrt_newton_core
  import isqrt_pkg::*;
#(
  parameter int NEWTON_STEPS = NEWTON_STEPS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [VALUE_W-1:0] value,
  output logic                     done,
  output logic signed [ROOT_W-1:0]  root
);

  localparam int STEP_W = $clog2(NEWTON_STEPS + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NEWTON_STEPS);

  logic [PC_W-1:0]      pc;
  logic [PC_W-1:0]      pc_next;
  ctrl_t                ctrl;
  logic                 jump;

  logic [MAG_W-1:0]     radicand;
  logic [EST_W-1:0]     est;
  logic [STEP_W-1:0]    steps;
  logic [MAG_W-1:0]     quo;
  logic [EST_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] div_count;

  logic [EST_W:0]       rem_shift;
  logic [EST_W:0]       rem_diff;
  logic                 qbit;
  logic [VALUE_W-1:0]   sum;

  assign ctrl = control_word(pc);
  assign busy = (pc != PC_IDLE);
  assign done = (ctrl.op == OP_EMIT);
  assign root = signed'(est[ROOT_W-1:0]);

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NOT_START: jump = !start;
      COND_STOP:      jump = (est == '0) || (steps == STEP_LAST);
      COND_DIV_BUSY:  jump = (div_count != DIV_LAST);
      default:        jump = 1'b1;
    endcase
    pc_next = jump ? ctrl.target : pc + PC_W'(1);
  end

  assign rem_shift = {rem, quo[MAG_W-1]};
  assign rem_diff  = rem_shift - {1'b0, est};
  assign qbit      = !rem_diff[EST_W];
  assign sum       = {1'b0, quo} + VALUE_W'(est);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (start) begin
          radicand <= value[MAG_W-1:0];
          est      <= value[VALUE_W-1] ? '0 : START_ESTIMATE;
          steps    <= '0;
        end
      end
      OP_DIV_INIT: begin
        quo       <= radicand;
        rem       <= '0;
        div_count <= '0;
      end
      OP_DIV_STEP: begin
        rem       <= qbit ? rem_diff[EST_W-1:0] : rem_shift[EST_W-1:0];
        quo       <= {quo[MAG_W-2:0], qbit};
        div_count <= div_count + DIV_CNT_W'(1);
      end
      OP_UPDATE: begin
        est   <= sum[EST_W:1];
        steps <= steps + STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("Transfer accepted but the sequencer did not leave idle.");

  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("Sequencer did not return to idle after the result.");

  a_update_nonzero: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_DINIT) |-> (est != '0) && (steps != STEP_LAST))
    else $error("Division started with a zero estimate or no updates left.");
`endif

endmodule

// File: sim/integer_sqrt_newton_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root core testbench
// Sends signed 64-bit radicands through the start/busy command port and compares
// every root strobed on done with a Newton-iteration predictor or a typed root.
// A short table of edge cases comes first, then several hundred random
// radicands with random gaps between requests.
// ----------------------------------------------------------------------------
module integer_sqrt_newton_core_tb;
  import isqrt_pkg::*;

  localparam int UPDATE_LIMIT = NEWTON_STEPS_DEFAULT;
  localparam int RANDOM_ITEMS = 600;
  localparam int NUM_ROWS = 22;

  typedef struct {
    logic [VALUE_W-1:0] value;
    bit                 typed;
    logic [ROOT_W-1:0]  root;
  } stim_row_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [ROOT_W-1:0]  root;
  } pending_root_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      done;
  logic signed [ROOT_W-1:0]  root;

  pending_root_t pending_roots[$];
  stim_row_t     stim_rows[NUM_ROWS];
  int            errors = 0;
  int            roots_checked = 0;
  int            radicands_sent = 0;
  int            negatives_sent = 0;
  bit            no_idle = 1'b0;

  integer_sqrt_newton_core #(
    .NEWTON_STEPS(UPDATE_LIMIT)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .value(value),
    .done (done),
    .root (root)
  );

  always #2 clk = ~clk;

  function automatic logic [ROOT_W-1:0] newton_root(input logic [VALUE_W-1:0] radicand);
    logic [VALUE_W-1:0] est;
    int                 k;
    est = VALUE_W'(16'h3fff);
    if (radicand[VALUE_W-1]) begin
      return '0;
    end
    for (k = 0; k < UPDATE_LIMIT && est != 0; k++) begin
      est = (radicand / est + est) >> 1;
    end
    return est[ROOT_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] random_radicand();
    logic [VALUE_W-1:0] r;
    logic [VALUE_W-1:0] s;
    int                 kind;
    int                 w;
    r = {$urandom, $urandom};
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      r[VALUE_W-1] = 1'b1;
    end else if (kind < 30) begin
      r = VALUE_W'($urandom_range(0, 1000));
    end else if (kind < 55) begin
      w = $urandom_range(1, 63);
      r = r & ((64'd1 << w) - 64'd1);
    end else if (kind < 75) begin
      s = VALUE_W'($urandom & 32'h7fff_ffff);
      r = s * s + VALUE_W'($urandom_range(0, 2)) - 64'd1;
      if (r[VALUE_W-1]) begin
        r = '0;
      end
    end else begin
      r[VALUE_W-1] = 1'b0;
    end
    return r;
  endfunction

  function automatic int request_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 40) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(20, 1200);
  endfunction

  // Holds the request until the transfer is taken, then records the expected root.
  task automatic send_radicand(input logic [VALUE_W-1:0] v, input bit typed,
                               input logic [ROOT_W-1:0] typed_root);
    pending_root_t entry;
    int            gap;
    gap = request_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    entry.value = v;
    entry.root = typed ? typed_root : newton_root(v);
    pending_roots.push_back(entry);
    radicands_sent++;
    if (v[VALUE_W-1]) begin
      negatives_sent++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pending_root_t head;
    if (!rst && done !== 1'b0) begin
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected root, expected none, actual %0d", $time, root);
        errors++;
      end else begin
        head = pending_roots.pop_front();
        roots_checked++;
        if (done !== 1'b1 || root !== head.root) begin
          $display("%0t: root mismatch for value %0d: expected %0d, actual %0d (done %b)",
                   $time, $signed(head.value), $signed(head.root), root, done);
          errors++;
        end
      end
    end
  end

  initial begin
    int i;
    stim_rows = '{
      '{64'd0,                   1'b1, 32'd0},
      '{64'hffff_ffff_ffff_ffff, 1'b1, 32'd0},
      '{64'h8000_0000_0000_0000, 1'b1, 32'd0},
      '{-64'sd16383,             1'b1, 32'd0},
      '{64'd1,                   1'b0, 32'd0},
      '{64'd2,                   1'b0, 32'd0},
      '{64'd3,                   1'b0, 32'd0},
      '{64'd4,                   1'b0, 32'd0},
      '{64'd15,                  1'b0, 32'd0},
      '{64'd16,                  1'b0, 32'd0},
      '{64'd16383,               1'b0, 32'd0},
      '{64'd16384,               1'b0, 32'd0},
      '{64'd268402689,           1'b0, 32'd0},
      '{64'd268435456,           1'b0, 32'd0},
      '{64'h0000_0000_ffff_ffff, 1'b0, 32'd0},
      '{64'h0000_0001_0000_0000, 1'b0, 32'd0},
      '{64'h0000_0100_0000_0000, 1'b0, 32'd0},
      '{64'h0004_0000_0000_0000, 1'b0, 32'd0},
      '{64'h3fff_ffff_ffff_ffff, 1'b0, 32'd0},
      '{64'h4000_0000_0000_0000, 1'b0, 32'd0},
      '{64'h7fff_ffff_ffff_fffe, 1'b0, 32'd0},
      '{64'h7fff_ffff_ffff_ffff, 1'b0, 32'd0}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < NUM_ROWS; i++) begin
      send_radicand(stim_rows[i].value, stim_rows[i].typed, stim_rows[i].root);
    end
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      send_radicand(random_radicand(), 1'b0, '0);
    end
    @(posedge clk);
    start <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    $display("Sent %0d radicands (%0d negative), including edge cases up to 2^63-1.",
             radicands_sent, negatives_sent);
    $display("Checked %0d roots against the predictor.", roots_checked);
    if (errors == 0) begin
      $display("integer_sqrt_newton_core_tb: clean");
    end else begin
      $display("integer_sqrt_newton_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("integer_sqrt_newton_core_tb: errors");
    $finish;
  end

endmodule
